/* hdl/gdfs_pkg.sv */
// Shared types and constants for the graph depth-first search engine.
// No dependencies; imported by gdfs_scan, the top level and the checker.
package gdfs_pkg;

   // Sizing of the graph storage
   localparam int MAX_NODES   = 32;
   localparam int MAX_EDGES   = 256;

   // Field widths
   localparam int NODE_W      = 5;
   localparam int CFG_W       = 6;
   localparam int EDGE_W      = 2 * NODE_W;
   localparam int VMAP_W      = 1 << NODE_W;

   // Edge store and work stack geometry
   localparam int EDGE_AW     = (MAX_EDGES > 1) ? $clog2(MAX_EDGES) : 1;
   localparam int EDGE_CW     = $clog2(MAX_EDGES + 1);
   localparam int STACK_DEPTH = MAX_EDGES + 1;
   localparam int STACK_AW    = $clog2(STACK_DEPTH);
   localparam int LEVEL_W     = $clog2(STACK_DEPTH + 1);

   // Effective cap on the node limit register
   localparam int NODE_CAP    = (MAX_NODES < VMAP_W) ? MAX_NODES : VMAP_W;
   localparam int CFG_RESET   = 32;

   typedef enum logic [1:0] {
      REQ_CLEAR     = 2'd0,
      REQ_ADD_DIR   = 2'd1,
      REQ_ADD_UNDIR = 2'd2,
      REQ_SEARCH    = 2'd3
   } req_code_type;

   typedef enum logic [1:0] {
      ST_OK       = 2'd0,
      ST_VISIT    = 2'd1,
      ST_BAD_NODE = 2'd2,
      ST_FULL     = 2'd3
   } status_code_type;

   typedef enum logic [2:0] {
      S_IDLE,
      S_EXEC,
      S_EDGE2,
      S_POP,
      S_POP_CHECK,
      S_SCAN
   } state_type;

   // Status from the edge scan unit back to the sequencer
   typedef struct packed {
      logic              push;
      logic [NODE_W-1:0] node;
      logic              done;
   } scan_status_type;

endpackage

/* hdl/gdfs_ram.sv */
// Generic single-write, single-read RAM with registered read data.
// No dependencies; used for the edge store and the work stack.
module gdfs_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                                      clock,
   input  logic                                      wr_en,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  logic [WIDTH-1:0]                          wr_data,
   input  logic                                      rd_en,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic [WIDTH-1:0]                          rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // Write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   // Registered read port
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

/* hdl/gdfs_scan.sv */
// Edge scan unit: walks the edge store one entry per cycle and compares each
// source against the current node. Depends on gdfs_pkg.
module gdfs_scan (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            scan_start,
   input  logic [gdfs_pkg::EDGE_CW-1:0]    edge_total,
   input  logic [gdfs_pkg::NODE_W-1:0]     cur_node,
   input  logic [gdfs_pkg::VMAP_W-1:0]     visited,
   input  logic [gdfs_pkg::EDGE_W-1:0]     edge_rd_data,
   output logic                            edge_rd_en,
   output logic [gdfs_pkg::EDGE_AW-1:0]    edge_rd_addr,
   output gdfs_pkg::scan_status_type       scan_status
);
   import gdfs_pkg::*;

   logic               active_ff, active_in;
   logic               rd_valid_ff, rd_valid_in;
   logic [EDGE_CW-1:0] idx_ff, idx_in;
   logic               more;
   logic [NODE_W-1:0]  from_node;
   logic [NODE_W-1:0]  to_node;
   logic               done;

   assign more      = idx_ff < edge_total;
   assign from_node = edge_rd_data[EDGE_W-1:NODE_W];
   assign to_node   = edge_rd_data[NODE_W-1:0];
   assign done      = active_ff && !more && !rd_valid_ff;

   // Issue one edge read per cycle while entries remain
   assign edge_rd_en   = active_ff && more;
   assign edge_rd_addr = idx_ff[EDGE_AW-1:0];

   always_comb begin
      idx_in      = idx_ff;
      active_in   = active_ff;
      rd_valid_in = active_ff && more;
      if (scan_start) begin
         idx_in    = '0;
         active_in = 1'b1;
      end else if (done) begin
         active_in = 1'b0;
      end else if (active_ff && more) begin
         idx_in = idx_ff + EDGE_CW'(1);
      end
   end

   // Compare the returned edge against the node being expanded
   always_comb begin
      scan_status.push = rd_valid_ff && (from_node == cur_node) && !visited[to_node];
      scan_status.node = to_node;
      scan_status.done = done;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         active_ff   <= 1'b0;
         rd_valid_ff <= 1'b0;
         idx_ff      <= '0;
      end else begin
         active_ff   <= active_in;
         rd_valid_ff <= rd_valid_in;
         idx_ff      <= idx_in;
      end
   end

endmodule

/* hdl/graph_dfs_traversal.sv */
// Top level of the graph depth-first search engine: sequencer, edge store,
// work stack and edge scan unit. Depends on gdfs_pkg, gdfs_ram, gdfs_scan.
//
// Usage:
//   A request beat is taken when start is high and busy is low; busy stays
//   high until the request's last result has been issued. req_type selects
//   clear graph, add directed edge, add undirected edge or run search.
//   Each result beat sits on the rsp_ ports for one cycle with rsp_valid
//   high; rsp_last marks the final beat of a request. The receiver cannot
//   stall, so results are never held back.
//   csr_node_count is written over csr_valid/csr_ready (ready is always high)
//   and must only change while busy is low.
// Sequencing:
//   Clear, directed edge, and any rejected request: the result beat is
//   registered in S_EXEC. Undirected edge: in S_EDGE2, after the reverse entry.
//   The next request can be taken at the edge that ends the last result beat.
//   Search: a setup state pushes the start node, each stack pop passes
//   S_POP and S_POP_CHECK, and each visited node scans the whole store in
//   S_SCAN, since the one scan unit reads the edge store one entry per cycle
//   for each node it expands. Busy drops as the last result appears.
// Reset:
//   Clears the edge count, the stack level, the visited map and the control
//   state, and sets node_count to 32. Memory contents are left as they are.
module graph_dfs_traversal (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          start,
   output logic                          busy,
   input  logic [1:0]                    req_type,
   input  logic [gdfs_pkg::NODE_W-1:0]   req_src_node,
   input  logic [gdfs_pkg::NODE_W-1:0]   req_dst_node,
   input  logic                          csr_valid,
   output logic                          csr_ready,
   input  logic [gdfs_pkg::CFG_W-1:0]    csr_node_count,
   output logic                          rsp_valid,
   output logic [1:0]                    rsp_status,
   output logic [gdfs_pkg::NODE_W-1:0]   rsp_visit_node,
   output logic                          rsp_last
);
   import gdfs_pkg::*;

   state_type          state_ff, state_in;
   req_code_type       req_ff;
   logic [NODE_W-1:0]  src_ff, dst_ff;
   logic [CFG_W-1:0]   node_count_ff;
   logic [EDGE_CW-1:0] edge_total_ff, edge_total_in;
   logic [VMAP_W-1:0]  visited_ff, visited_in;
   logic [LEVEL_W-1:0] level_ff, level_in;
   logic               pend_valid_ff, pend_valid_in;
   logic [NODE_W-1:0]  pend_node_ff, pend_node_in;
   logic               rsp_valid_ff, rsp_valid_in;
   status_code_type    rsp_status_ff, rsp_status_in;
   logic [NODE_W-1:0]  rsp_node_ff, rsp_node_in;
   logic               rsp_last_ff, rsp_last_in;

   // Memory ports
   logic                edge_wr_en;
   logic [EDGE_AW-1:0]  edge_wr_addr;
   logic [EDGE_W-1:0]   edge_wr_data;
   logic                edge_rd_en;
   logic [EDGE_AW-1:0]  edge_rd_addr;
   logic [EDGE_W-1:0]   edge_rd_data;
   logic                stk_wr_en;
   logic [STACK_AW-1:0] stk_wr_addr;
   logic [NODE_W-1:0]   stk_wr_data;
   logic                stk_rd_en;
   logic [STACK_AW-1:0] stk_rd_addr;
   logic [NODE_W-1:0]   stk_rd_data;

   logic                scan_start;
   scan_status_type     scan_status;

   // Request decode
   logic [CFG_W-1:0]    node_limit;
   logic                src_bad, dst_bad;
   logic                edge_full;
   logic [EDGE_CW:0]    edge_need;
   logic [LEVEL_W-1:0]  level_dec;
   logic                level_empty;
   logic                popped_seen;
   logic                accept;

   assign accept      = start && (state_ff == S_IDLE);
   assign node_limit  = (node_count_ff < CFG_W'(NODE_CAP)) ? node_count_ff : CFG_W'(NODE_CAP);
   assign src_bad     = {1'b0, src_ff} >= node_limit;
   assign dst_bad     = {1'b0, dst_ff} >= node_limit;
   assign edge_need   = (req_ff == REQ_ADD_UNDIR) ? (EDGE_CW + 1)'(2) : (EDGE_CW + 1)'(1);
   assign edge_full   = ({1'b0, edge_total_ff} + edge_need) > (EDGE_CW + 1)'(MAX_EDGES);
   assign level_dec   = level_ff - LEVEL_W'(1);
   assign level_empty = (level_ff == '0);
   assign popped_seen = visited_ff[stk_rd_data];

   // Next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         S_IDLE: begin
            if (accept) begin
               state_in = S_EXEC;
            end
         end
         S_EXEC: begin
            state_in = S_IDLE;
            if (req_ff == REQ_SEARCH) begin
               if (!src_bad) begin
                  state_in = S_POP;
               end
            end else if (req_ff == REQ_ADD_UNDIR) begin
               if (!src_bad && !dst_bad && !edge_full) begin
                  state_in = S_EDGE2;
               end
            end
         end
         S_EDGE2: begin
            state_in = S_IDLE;
         end
         S_POP: begin
            state_in = level_empty ? S_IDLE : S_POP_CHECK;
         end
         S_POP_CHECK: begin
            state_in = popped_seen ? S_POP : S_SCAN;
         end
         S_SCAN: begin
            if (scan_status.done) begin
               state_in = S_POP;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // Datapath control and result generation
   always_comb begin
      edge_wr_en    = 1'b0;
      edge_wr_addr  = edge_total_ff[EDGE_AW-1:0];
      edge_wr_data  = {src_ff, dst_ff};
      stk_wr_en     = 1'b0;
      stk_wr_addr   = level_ff[STACK_AW-1:0];
      stk_wr_data   = scan_status.node;
      stk_rd_en     = 1'b0;
      stk_rd_addr   = level_dec[STACK_AW-1:0];
      scan_start    = 1'b0;
      edge_total_in = edge_total_ff;
      visited_in    = visited_ff;
      level_in      = level_ff;
      pend_valid_in = pend_valid_ff;
      pend_node_in  = pend_node_ff;
      rsp_valid_in  = 1'b0;
      rsp_status_in = ST_OK;
      rsp_node_in   = '0;
      rsp_last_in   = 1'b0;
      case (state_ff)
         S_EXEC: begin
            case (req_ff)
               REQ_CLEAR: begin
                  edge_total_in = '0;
                  rsp_valid_in  = 1'b1;
                  rsp_last_in   = 1'b1;
               end
               REQ_SEARCH: begin
                  if (src_bad) begin
                     rsp_valid_in  = 1'b1;
                     rsp_status_in = ST_BAD_NODE;
                     rsp_last_in   = 1'b1;
                  end else begin
                     // Reset the map and push the start node
                     visited_in    = '0;
                     stk_wr_en     = 1'b1;
                     stk_wr_addr   = '0;
                     stk_wr_data   = src_ff;
                     level_in      = LEVEL_W'(1);
                     pend_valid_in = 1'b0;
                  end
               end
               default: begin
                  if (src_bad || dst_bad) begin
                     rsp_valid_in  = 1'b1;
                     rsp_status_in = ST_BAD_NODE;
                     rsp_last_in   = 1'b1;
                  end else if (edge_full) begin
                     rsp_valid_in  = 1'b1;
                     rsp_status_in = ST_FULL;
                     rsp_last_in   = 1'b1;
                  end else begin
                     edge_wr_en    = 1'b1;
                     edge_total_in = edge_total_ff + EDGE_CW'(1);
                     if (req_ff == REQ_ADD_DIR) begin
                        rsp_valid_in = 1'b1;
                        rsp_last_in  = 1'b1;
                     end
                  end
               end
            endcase
         end
         S_EDGE2: begin
            // Store the reverse entry of an undirected edge
            edge_wr_en    = 1'b1;
            edge_wr_data  = {dst_ff, src_ff};
            edge_total_in = edge_total_ff + EDGE_CW'(1);
            rsp_valid_in  = 1'b1;
            rsp_last_in   = 1'b1;
         end
         S_POP: begin
            if (level_empty) begin
               // Stack drained: the held visit is the final beat
               rsp_valid_in  = 1'b1;
               rsp_status_in = ST_VISIT;
               rsp_node_in   = pend_node_ff;
               rsp_last_in   = 1'b1;
               pend_valid_in = 1'b0;
            end else begin
               stk_rd_en = 1'b1;
               level_in  = level_dec;
            end
         end
         S_POP_CHECK: begin
            if (!popped_seen) begin
               // Release the previous visit, hold this one until the next
               if (pend_valid_ff) begin
                  rsp_valid_in  = 1'b1;
                  rsp_status_in = ST_VISIT;
                  rsp_node_in   = pend_node_ff;
               end
               pend_valid_in = 1'b1;
               pend_node_in  = stk_rd_data;
               visited_in    = visited_ff | (VMAP_W'(1) << stk_rd_data);
               scan_start    = 1'b1;
            end
         end
         S_SCAN: begin
            if (scan_status.push && (level_ff < LEVEL_W'(STACK_DEPTH))) begin
               stk_wr_en = 1'b1;
               level_in  = level_ff + LEVEL_W'(1);
            end
         end
         default: begin
         end
      endcase
   end

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_IDLE;
         node_count_ff <= CFG_W'(CFG_RESET);
         edge_total_ff <= '0;
         visited_ff    <= '0;
         level_ff      <= '0;
         pend_valid_ff <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         edge_total_ff <= edge_total_in;
         visited_ff    <= visited_in;
         level_ff      <= level_in;
         pend_valid_ff <= pend_valid_in;
         rsp_valid_ff  <= rsp_valid_in;
         if (csr_valid) begin
            node_count_ff <= csr_node_count;
         end
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      if (accept) begin
         req_ff <= req_code_type'(req_type);
         src_ff <= req_src_node;
         dst_ff <= req_dst_node;
      end
      pend_node_ff  <= pend_node_in;
      rsp_status_ff <= rsp_status_in;
      rsp_node_ff   <= rsp_node_in;
      rsp_last_ff   <= rsp_last_in;
   end

   gdfs_ram #(
      .WIDTH (EDGE_W),
      .DEPTH (MAX_EDGES)
   ) u_edge_ram (
      .clock   (clock),
      .wr_en   (edge_wr_en),
      .wr_addr (edge_wr_addr),
      .wr_data (edge_wr_data),
      .rd_en   (edge_rd_en),
      .rd_addr (edge_rd_addr),
      .rd_data (edge_rd_data)
   );

   gdfs_ram #(
      .WIDTH (NODE_W),
      .DEPTH (STACK_DEPTH)
   ) u_stack_ram (
      .clock   (clock),
      .wr_en   (stk_wr_en),
      .wr_addr (stk_wr_addr),
      .wr_data (stk_wr_data),
      .rd_en   (stk_rd_en),
      .rd_addr (stk_rd_addr),
      .rd_data (stk_rd_data)
   );

   gdfs_scan u_scan (
      .clock        (clock),
      .reset        (reset),
      .scan_start   (scan_start),
      .edge_total   (edge_total_ff),
      .cur_node     (pend_node_ff),
      .visited      (visited_ff),
      .edge_rd_data (edge_rd_data),
      .edge_rd_en   (edge_rd_en),
      .edge_rd_addr (edge_rd_addr),
      .scan_status  (scan_status)
   );

   assign busy           = (state_ff != S_IDLE);
   assign csr_ready      = 1'b1;
   assign rsp_valid      = rsp_valid_ff;
   assign rsp_status     = rsp_status_ff;
   assign rsp_visit_node = rsp_node_ff;
   assign rsp_last       = rsp_last_ff;

endmodule

/* hdl/gdfs_checker.sv */
// Port-level checks for the graph depth-first search engine, bound to the
// top level. Depends on gdfs_pkg and graph_dfs_traversal.
module gdfs_checker (
   input logic                          clock,
   input logic                          reset,
   input logic                          start,
   input logic                          busy,
   input logic                          rsp_valid,
   input logic [1:0]                    rsp_status,
   input logic [gdfs_pkg::NODE_W-1:0]   rsp_visit_node,
   input logic                          rsp_last
);
   import gdfs_pkg::*;

   // Reset leaves the block idle with no beat pending
   a_reset_idle: assert property (@(posedge clock)
      reset |=> (!busy && !rsp_valid))
      else $error("block not idle after reset");

   // An accepted request keeps the block busy in the next cycle
   a_accept_busy: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |=> busy)
      else $error("busy not raised after accept");

   // A non-final beat only appears while the search is still running
   a_more_busy: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_last) |-> busy)
      else $error("non-final beat while idle");

   // Status-only beats are always final and carry node zero
   a_status_final: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && (rsp_status != ST_VISIT)) |-> (rsp_last && (rsp_visit_node == '0)))
      else $error("status beat not final or carries a node");

endmodule

bind graph_dfs_traversal gdfs_checker u_gdfs_checker (.*);
